// ----- rtl/core/lubr_pkg.sv -----
// Shared constants and types for the longest unique byte run block.
package lubr_pkg;

  localparam int MAX_LEN = 65536;
  localparam int SYMBOLS = 256;
  localparam int SYM_W   = $clog2(SYMBOLS);
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic valid;
    sym_t sym;
    logic last;
  } stage_t;

  typedef struct packed {
    logic en;
    sym_t addr;
    pos_t data;
  } wr_t;

endpackage

// ----- rtl/core/lubr_if.sv -----
// Stream interfaces for the byte input and the result output.
interface lubr_text_if
  import lubr_pkg::*;
();
  logic valid;
  logic ready;
  sym_t byte_value;
  logic is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink (input valid, input byte_value, input is_last, output ready);
endinterface

interface lubr_result_if
  import lubr_pkg::*;
();
  logic valid;
  logic ready;
  pos_t best_start;
  len_t best_length;
  logic too_long;

  modport source (output valid, output best_start, output best_length, output too_long,
                  input ready);
  modport sink (input valid, input best_start, input best_length, input too_long,
                output ready);
endinterface

// ----- rtl/core/lubr_pos_ram.sv -----
// Last-seen position table: one write port, one registered read port.
module lubr_pos_ram
  import lubr_pkg::*;
(
  input  logic clk,
  input  logic ren,
  input  sym_t raddr,
  output pos_t rdata,
  input  wr_t  wr
);

  pos_t mem [SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lubr_tracker.sv -----
// Window and best-run tracking, valid bits, write forwarding and result register.
module lubr_tracker
  import lubr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  stage_t stage,
  input  pos_t rdata,
  output logic go,
  output wr_t  wr,
  lubr_result_if.source result
);

  localparam len_t POS_LIMIT = LEN_W'(MAX_LEN);

  logic [SYMBOLS-1:0] seen_valid;
  pos_t window_start;
  len_t position;
  pos_t best_run_start;
  len_t best_run_length;
  logic overflowed;

  logic fwd_valid;
  sym_t fwd_sym;
  pos_t fwd_pos;

  logic in_range;
  logic moved;
  logic better;
  pos_t idx;
  pos_t last_pos;
  pos_t start_next;
  len_t run;

  always_comb begin
    go        = stage.valid && (!stage.last || !result.valid || result.ready);
    in_range  = position < POS_LIMIT;
    idx       = position[POS_W-1:0];
    last_pos  = (fwd_valid && fwd_sym == stage.sym) ? fwd_pos : rdata;
    moved     = seen_valid[stage.sym] && (last_pos >= window_start);
    start_next = moved ? POS_W'(last_pos + 1'b1) : window_start;
    run       = LEN_W'({1'b0, idx} + 1'b1 - {1'b0, start_next});
    better    = run > best_run_length;
    wr.en     = go && in_range;
    wr.addr   = stage.sym;
    wr.data   = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid      <= '0;
      window_start    <= '0;
      position        <= '0;
      best_run_start  <= '0;
      best_run_length <= '0;
      overflowed      <= 1'b0;
      fwd_valid       <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (wr.en) begin
        fwd_valid <= 1'b1;
      end
      if (go) begin
        if (stage.last) begin
          seen_valid      <= '0;
          window_start    <= '0;
          position        <= '0;
          best_run_start  <= '0;
          best_run_length <= '0;
          overflowed      <= 1'b0;
          result.valid    <= 1'b1;
        end else if (in_range) begin
          seen_valid[stage.sym] <= 1'b1;
          window_start          <= start_next;
          position              <= position + 1'b1;
          if (better) begin
            best_run_start  <= start_next;
            best_run_length <= run;
          end
        end else begin
          overflowed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_sym <= wr.addr;
      fwd_pos <= wr.data;
    end
    if (go && stage.last) begin
      result.best_start  <= (in_range && better) ? start_next : best_run_start;
      result.best_length <= (in_range && better) ? run : best_run_length;
      result.too_long    <= overflowed || !in_range;
    end
  end

endmodule

// ----- rtl/core/longest_unique_byte_run.sv -----
// Longest repeat-free byte run: takes one byte per cycle; a byte is looked up in the
// 256-entry last-position RAM in the cycle it is accepted and resolved from the stage
// register, with the previous write forwarded; the result is registered when the
// last byte resolves. The last byte of a string stalls input only while the
// previous result is still untaken. Per-symbol valid bits clear at once on the last
// byte, so there is no clearing pass; bytes beyond MAX_LEN are dropped and flagged.
module longest_unique_byte_run
  import lubr_pkg::*;
(
  input logic clk,
  input logic rst,
  lubr_text_if.sink     text,
  lubr_result_if.source result
);

  stage_t stage;
  logic   go;
  logic   take;
  pos_t   rdata;
  wr_t    wr;

  assign text.ready = !stage.valid || go;
  assign take       = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (take) begin
      stage.valid <= 1'b1;
    end else if (go) begin
      stage.valid <= 1'b0;
    end
    if (take) begin
      stage.sym  <= text.byte_value;
      stage.last <= text.is_last;
    end
  end

  lubr_pos_ram u_ram (
    .clk   (clk),
    .ren   (take),
    .raddr (text.byte_value),
    .rdata (rdata),
    .wr    (wr)
  );

  lubr_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .stage  (stage),
    .rdata  (rdata),
    .go     (go),
    .wr     (wr),
    .result (result)
  );

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !go |-> stage.last && result.valid && !result.ready)
    else $error("stage stalled without a full result register");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    go && stage.last |=> result.valid)
    else $error("last byte retired without a result");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    take |=> stage.valid)
    else $error("accepted byte lost before resolve stage");
`endif

endmodule
